/* design/qrs_pkg.sv */
// Shared types and root-kind codes for the quadratic root solver.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_REAL    = 2'd0;
  localparam kind_t KIND_COMPLEX = 2'd1;
  localparam kind_t KIND_REPEAT  = 2'd2;
  localparam kind_t KIND_AZERO   = 2'd3;

  // fractional bits of the Q16.16 results and of the discriminant's square root
  localparam int FRAC_BITS = 16;

endpackage

/* design/qrs_sqrt.sv */
// Pipelined floor square root, one result bit per stage, with a tag that
// travels alongside the data. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt #(
  parameter int RT_W  = 33,
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_in,
  input  logic [2*RT_W-1:0]   x_in,
  input  logic [TAG_W-1:0]    tag_in,
  output logic                valid_out,
  output logic [RT_W-1:0]     root_out,
  output logic [TAG_W-1:0]    tag_out
);
  import qrs_pkg::*;

  localparam int XP   = 2 * RT_W;
  localparam int RM_W = RT_W + 3;

  logic              vld  [0:RT_W];
  logic [RM_W-1:0]   rem  [0:RT_W];
  logic [RT_W-1:0]   root [0:RT_W];
  logic [XP-1:0]     xsh  [0:RT_W];
  logic [TAG_W-1:0]  tag  [0:RT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= valid_in;
    end
    rem[0]  <= '0;
    root[0] <= '0;
    xsh[0]  <= x_in;
    tag[0]  <= tag_in;
  end

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic [RM_W-1:0] rem_sh;
    logic [RM_W-1:0] trial;
    logic            ge;

    always_comb begin
      // bring down the next two bits and try root*4+1
      rem_sh = {rem[k][RM_W-3:0], xsh[k][XP-1:XP-2]};
      trial  = {1'b0, root[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
      root[k+1] <= {root[k][RT_W-2:0], ge};
      xsh[k+1]  <= {xsh[k][XP-3:0], 2'b00};
      tag[k+1]  <= tag[k];
    end
  end

  assign valid_out = vld[RT_W];
  assign root_out  = root[RT_W];
  assign tag_out   = tag[RT_W];

endmodule

/* design/qrs_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// tag that travels alongside the data. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 17,
  parameter int TAG_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              valid_out,
  output logic [NUM_W-1:0]  quot_out,
  output logic [TAG_W-1:0]  tag_out
);
  import qrs_pkg::*;

  logic              vld [0:NUM_W];
  logic [DEN_W-1:0]  rem [0:NUM_W];
  logic [NUM_W-1:0]  nq  [0:NUM_W];
  logic [DEN_W-1:0]  dv  [0:NUM_W];
  logic [TAG_W-1:0]  tag [0:NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= valid_in;
    end
    rem[0] <= '0;
    nq[0]  <= num_in;
    dv[0]  <= den_in;
    tag[0] <= tag_in;
  end

  for (genvar j = 0; j < NUM_W; j++) begin : g_stage
    logic [DEN_W:0] r_sh;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
      r_sh = {rem[j], nq[j][NUM_W-1]};
      diff = r_sh - {1'b0, dv[j]};
      ge   = (r_sh >= {1'b0, dv[j]});
    end

    // numerator bits shift out the top while quotient bits shift in below
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      rem[j+1] <= ge ? diff[DEN_W-1:0] : r_sh[DEN_W-1:0];
      nq[j+1]  <= {nq[j][NUM_W-2:0], ge};
      dv[j+1]  <= dv[j];
      tag[j+1] <= tag[j];
    end
  end

  assign valid_out = vld[NUM_W];
  assign quot_out  = nq[NUM_W];
  assign tag_out   = tag[NUM_W];

endmodule

/* design/quadratic_root_solver.sv */
// Quadratic root solver: products, discriminant, pipelined square root and
// two pipelined dividers, one stage per square-root bit and per quotient
// bit; throughput one item per cycle, busy stays low and the receiver
// cannot stall.
// Synchronous reset clears the valid bits of every stage; data regs hold.
// Depends on qrs_pkg, qrs_sqrt, qrs_div.
`timescale 1ns / 1ps

module quadratic_root_solver #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COEF_WIDTH-1:0] coeff_a,
  input  logic signed [COEF_WIDTH-1:0] coeff_b,
  input  logic signed [COEF_WIDTH-1:0] coeff_c,
  output logic                         done,
  output qrs_pkg::kind_t               root_kind,
  output logic signed [31:0]           root_one,
  output logic signed [31:0]           root_two
);
  import qrs_pkg::*;

  localparam int W     = COEF_WIDTH;
  localparam int M_W   = 2 * W + 2;
  localparam int RT_W  = W + 17;
  localparam int NB_W  = W + 17;
  localparam int DN_W  = W + 1;
  localparam int SUM_W = W + 19;
  localparam int NUM_W = W + 18;
  localparam int EXT_W = (NUM_W + 1 > 33) ? NUM_W + 1 : 33;
  localparam int T1_W  = 2 + NB_W + DN_W;
  localparam int LAT   = RT_W + NUM_W + 4;

  // ---- stage 1: magnitudes and products
  logic [W-1:0]    mag_a, mag_b, mag_c;
  logic            v1;
  logic [2*W-1:0]  b2;
  logic [2*W-1:0]  ac;
  logic            opp;
  logic            azero;
  logic [W-1:0]    a1, b1;

  always_comb begin
    mag_a = coeff_a[W-1] ? (~coeff_a + 1'b1) : coeff_a;
    mag_b = coeff_b[W-1] ? (~coeff_b + 1'b1) : coeff_b;
    mag_c = coeff_c[W-1] ? (~coeff_c + 1'b1) : coeff_c;
  end

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start && !busy;
    end
    b2    <= mag_b * mag_b;
    ac    <= mag_a * mag_c;
    opp   <= (coeff_c != '0) && (coeff_a[W-1] != coeff_c[W-1]);
    azero <= (coeff_a == '0);
    a1    <= coeff_a;
    b1    <= coeff_b;
  end

  // ---- stage 2: |discriminant|, kind, -b<<16 and 2a, feeding the root unit
  logic [M_W-1:0]         q4, b2e, dmag;
  kind_t                  kind2;
  logic signed [NB_W-1:0] nb, b_ext;
  logic signed [DN_W-1:0] den;

  always_comb begin
    q4  = {ac, 2'b00};
    b2e = {2'b00, b2};
    if (opp) begin
      dmag  = b2e + q4;
      kind2 = KIND_REAL;
    end else if (b2e > q4) begin
      dmag  = b2e - q4;
      kind2 = KIND_REAL;
    end else if (b2e < q4) begin
      dmag  = q4 - b2e;
      kind2 = KIND_COMPLEX;
    end else begin
      dmag  = '0;
      kind2 = KIND_REPEAT;
    end
    if (azero) begin
      kind2 = KIND_AZERO;
    end
    b_ext = {b1[W-1], b1, 16'b0};
    nb    = -b_ext;
    den   = {a1, 1'b0};
  end

  logic               sq_v;
  logic [RT_W-1:0]    sq_root;
  logic [T1_W-1:0]    sq_tag;

  qrs_sqrt #(.RT_W(RT_W), .TAG_W(T1_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (v1),
    .x_in      ({dmag, 32'b0}),
    .tag_in    ({kind2, nb, den}),
    .valid_out (sq_v),
    .root_out  (sq_root),
    .tag_out   (sq_tag)
  );

  // ---- numerators and signs, feeding the dividers
  kind_t                   kind3;
  logic signed [NB_W-1:0]  nb3;
  logic signed [DN_W-1:0]  den3;
  logic signed [SUM_W-1:0] nb_e, s_e, num1, num2;
  logic [SUM_W-1:0]        mag1, mag2;
  logic [DN_W-1:0]         den_mag;
  logic                    neg1, neg2, cplx;

  always_comb begin
    {kind3, nb3, den3} = sq_tag;
    cplx    = (kind3 == KIND_COMPLEX);
    nb_e    = {{2{nb3[NB_W-1]}}, nb3};
    s_e     = {2'b00, sq_root};
    num1    = cplx ? nb_e : (nb_e + s_e);
    num2    = cplx ? s_e : (nb_e - s_e);
    den_mag = den3[DN_W-1] ? (~den3 + 1'b1) : den3;
    mag1    = num1[SUM_W-1] ? (~num1 + 1'b1) : num1;
    mag2    = num2[SUM_W-1] ? (~num2 + 1'b1) : num2;
    neg1    = num1[SUM_W-1] ^ den3[DN_W-1];
    // the imaginary part divides by |2a| and is never negative
    neg2    = cplx ? 1'b0 : (num2[SUM_W-1] ^ den3[DN_W-1]);
  end

  logic             d1_v, d2_v;
  logic [NUM_W-1:0] quo1, quo2;
  logic [2:0]       d1_tag;
  logic             d2_tag;

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DN_W), .TAG_W(3)) u_div_one (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sq_v),
    .num_in    (mag1[NUM_W-1:0]),
    .den_in    (den_mag),
    .tag_in    ({kind3, neg1}),
    .valid_out (d1_v),
    .quot_out  (quo1),
    .tag_out   (d1_tag)
  );

  qrs_div #(.NUM_W(NUM_W), .DEN_W(DN_W), .TAG_W(1)) u_div_two (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (sq_v),
    .num_in    (mag2[NUM_W-1:0]),
    .den_in    (den_mag),
    .tag_in    (neg2),
    .valid_out (d2_v),
    .quot_out  (quo2),
    .tag_out   (d2_tag)
  );

  // ---- sign fix, saturation, output register
  function automatic logic [31:0] sat_root(input logic [NUM_W-1:0] mag,
                                           input logic neg);
    logic [EXT_W-1:0]  ext;
    logic [EXT_W-1:0]  sv;
    logic [EXT_W-32:0] hi;
    ext = EXT_W'(mag);
    sv  = neg ? (~ext + 1'b1) : ext;
    hi  = sv[EXT_W-1:31];
    if ((|hi) && !(&hi)) begin
      return sv[EXT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return sv[31:0];
  endfunction

  kind_t kind4;
  assign kind4 = d1_tag[2:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d1_v && d2_v;
    end
    root_kind <= kind4;
    if (kind4 == KIND_AZERO) begin
      root_one <= '0;
      root_two <= '0;
    end else begin
      root_one <= sat_root(quo1, d1_tag[0]);
      root_two <= sat_root(quo2, d2_tag);
    end
  end

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted item");

  a_azero_zero: assert property (@(posedge clk) disable iff (rst)
    (done && root_kind == KIND_AZERO) |-> (root_one == 0 && root_two == 0))
    else $error("a is zero but roots are not zero");

  a_imag_nonneg: assert property (@(posedge clk) disable iff (rst)
    (done && root_kind == KIND_COMPLEX) |-> !root_two[31])
    else $error("negative imaginary magnitude");

  a_repeat_same: assert property (@(posedge clk) disable iff (rst)
    (done && root_kind == KIND_REPEAT) |-> (root_one == root_two))
    else $error("repeated root with differing values");

endmodule

/* sim/tb_top.sv */
// Testbench for quadratic_root_solver: random and directed coefficient items,
// results checked against an in-bench fixed-point root predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`timescale 1ns / 1ps

module tb_top;
  import qrs_pkg::*;

  localparam int CW = 16;
  localparam int LATENCY = 2 * CW + 39;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coeffs_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] r1;
    logic signed [31:0] r2;
  } roots_t;

  logic clk, rst, start, busy, done;
  logic signed [CW-1:0] coeff_a, coeff_b, coeff_c;
  kind_t root_kind;
  logic signed [31:0] root_one, root_two;

  coeffs_t pending_q[$];
  roots_t  roots_q[$];
  int      burst_left, gap_left, errors;
  bit      hold_off;

  quadratic_root_solver #(.COEF_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coeff_a(coeff_a), .coeff_b(coeff_b), .coeff_c(coeff_c),
    .done(done), .root_kind(root_kind), .root_one(root_one), .root_two(root_two)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] cand;
    r = 0;
    for (int k = 49; k >= 0; k--) begin
      cand = r | (64'd1 << k);
      if ({64'd0, cand} * {64'd0, cand} <= n) r = cand;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(coeffs_t x);
    roots_t res;
    logic signed [127:0] a, b, c, d, s, den, nb;
    a = x.a; b = x.b; c = x.c;
    if (a == 0) begin
      res.kind = KIND_AZERO; res.r1 = 0; res.r2 = 0;
      return res;
    end
    d = b * b - 4 * a * c;
    s = isqrt((d < 0 ? -d : d) << 32);
    den = 2 * a;
    nb = -(b * 65536);
    if (d > 0) begin
      res.kind = KIND_REAL;
      res.r1 = sat32((nb + s) / den);
      res.r2 = sat32((nb - s) / den);
    end else if (d < 0) begin
      res.kind = KIND_COMPLEX;
      res.r1 = sat32(nb / den);
      res.r2 = sat32(s / (den < 0 ? -den : den));
    end else begin
      res.kind = KIND_REPEAT;
      res.r1 = sat32(nb / den);
      res.r2 = res.r1;
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return CW'($urandom_range(0, 7) - 3);
      3: return CW'($urandom_range(0, 1023) - 512);
      default: return CW'($urandom);
    endcase
  endfunction

  // driver: bursts of items with random gaps; hold_off drains the pipe
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) void'(pending_q.pop_front());
      if (hold_off || pending_q.size() == 0) begin
        start <= 1'b0;
      end else if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        {coeff_a, coeff_b, coeff_c} <= pending_q[0];
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
          gap_left <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end
      end
      if (start && !busy) roots_q.push_back(solve_roots({coeff_a, coeff_b, coeff_c}));
    end
  end

  // monitor
  always @(posedge clk) begin
    roots_t want;
    if (!rst && done) begin
      if (roots_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        want = roots_q.pop_front();
        if (root_kind !== want.kind) begin
          $error("root_kind exp %0d got %0d", want.kind, root_kind); errors++;
        end
        if (root_one !== want.r1) begin
          $error("root_one exp %0d got %0d", want.r1, root_one); errors++;
        end
        if (root_two !== want.r2) begin
          $error("root_two exp %0d got %0d", want.r2, root_two); errors++;
        end
      end
    end
  end

  initial begin
    logic [CW-1:0] ext[6];
    coeffs_t x;
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0100};
    errors = 0; hold_off = 0;
    rst = 1; start = 0; coeff_a = 0; coeff_b = 0; coeff_c = 0;
    // directed: a zero, repeated (a=256,b=512,c=256), complex, real, extremes, negative a
    pending_q.push_back('{16'h0000, 16'h1234, 16'h0100});
    pending_q.push_back('{16'h0100, 16'h0200, 16'h0100});
    pending_q.push_back('{16'h0100, 16'h0000, 16'h0100});
    pending_q.push_back('{16'h0100, 16'h0000, 16'hFF00});
    pending_q.push_back('{16'hFF00, 16'h0300, 16'h0100});
    pending_q.push_back('{16'hFF00, 16'h0000, 16'hFF00});
    pending_q.push_back('{16'h0001, 16'h7FFF, 16'h0000});
    pending_q.push_back('{16'h0001, 16'h0000, 16'h0001});
    for (int i = 0; i < 12; i++)
      pending_q.push_back('{ext[i % 6], ext[(i / 2) % 6], ext[(i + 3) % 6]});
    repeat (5) @(posedge clk);
    rst <= 0;
    for (int n = 0; n < 1150; n++) begin
      x.a = pick_coef(); x.b = pick_coef(); x.c = pick_coef();
      if ($urandom_range(0, 9) == 0)
        x.c = CW'((x.b * x.b) / (4 * ((x.a == 0) ? 1 : x.a)));
      pending_q.push_back(x);
      if (n == 500) begin
        while (pending_q.size() > 0) @(posedge clk);
        hold_off = 1;
        while (roots_q.size() > 0) @(posedge clk);
        hold_off = 0;
      end
    end
    while (pending_q.size() > 0) @(posedge clk);
    while (roots_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
